FILE: rtl/core/mandelbrot_escape_time_defines.svh
// ----------------------------------------------------------------------------
// mandelbrot escape time assertion macros
// shared property shapes for the checker of the escape time block
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// same-cycle implication, held off during reset
`define MBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset itself
`define MBE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// types and constants shared by the escape time ring and its checker
// ----------------------------------------------------------------------------
package mbe_pkg;

  // iteration limit and ring length
  localparam int MAX_ITER  = 256;
  localparam int NUM_CELLS = 8;

  // fixed point layout of c and z, q3.28 in 31 bits
  localparam int Q_W    = 31;
  localparam int FRAC_W = 28;

  // product, square and update sum widths
  localparam int PROD_W = 2 * Q_W;
  localparam int SQ_W   = PROD_W - 1;
  localparam int SUM_W  = PROD_W + 2;

  // iteration counter and result field widths
  localparam int CNT_W   = $clog2(MAX_ITER + 1);
  localparam int COUNT_W = 9;

  // saturation bounds of a z component
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // four in the scale of a square, compared strictly
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(1) << (2 * FRAC_W + 2);

  // iteration limit as a counter value and as the result field shows it
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_ITER);
  localparam logic [CNT_W+COUNT_W-1:0] MAX_EXT = (CNT_W+COUNT_W)'(MAX_ITER);
  localparam logic [COUNT_W-1:0] MAX_COUNT_FIELD = MAX_EXT[COUNT_W-1:0];

  // one point travelling round the ring
  typedef struct packed {
    logic                  valid;
    logic                  done;
    logic                  esc;
    logic [CNT_W-1:0]      iter;
    logic signed [Q_W-1:0] cr;
    logic signed [Q_W-1:0] ci;
    logic signed [Q_W-1:0] re;
    logic signed [Q_W-1:0] im;
  } mbe_tok_t;

endpackage

FILE: rtl/core/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape time count of one q3.28 point against the iteration limit
// ----------------------------------------------------------------------------
// One point is worked on at a time. It circulates round a ring of NUM_CELLS
// (8) cells; each cell makes one pass of z = z*z + c, the first stage
// for the three 31x31 products and the second for the escape test and
// the saturated update. A point needs iteration_count + 2 cell visits when it
// escapes and MAX_ITER + 1 when it stays in the set, rounded up to whole
// trips round the ring, and its result register is loaded when it comes
// out of the last cell after its final trip. The next point is taken in
// the cycle after its predecessor's result is loaded; the result register
// lets that happen while the result is still stalled. A finished point that
// finds the result register full and stalled goes round the ring again.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
  import mbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [Q_W-1:0] in_c_real,
  input  logic signed [Q_W-1:0] in_c_imag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_W-1:0]    out_iteration_count,
  output logic                  out_in_set
);

  mbe_tok_t tok_chain [NUM_CELLS+1];
  mbe_tok_t head, tail;

  logic                     busy_r, busy_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]       count_r;
  logic                     in_set_r;

  logic                     in_xfer;
  logic                     load_out;
  logic [CNT_W-1:0]         fin_n;
  logic [CNT_W+COUNT_W-1:0] fin_ext;

  // input transfer only while the ring is empty
  assign in_xfer  = in_valid && !busy_r;
  assign in_stall = busy_r;

  assign tail     = tok_chain[NUM_CELLS];
  assign load_out = tail.valid && tail.done && (!out_valid_r || !out_stall);

  // ring entry: new point or the one coming round again
  always_comb begin
    head       = tail;
    head.valid = tail.valid && !load_out;
    if (in_xfer) begin
      head.valid = 1'b1;
      head.done  = 1'b0;
      head.esc   = 1'b0;
      head.iter  = '0;
      head.cr    = in_c_real;
      head.ci    = in_c_imag;
      head.re    = '0;
      head.im    = '0;
    end
  end

  assign tok_chain[0] = head;

  // ring of iteration cells
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mbe_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_chain[g]),
      .tok_o (tok_chain[g+1])
    );
  end

  // occupancy of the ring
  always_comb begin
    busy_nxt = busy_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end else if (load_out) begin
      busy_nxt = 1'b0;
    end
  end

  // final count, the escaping pass is not counted
  assign fin_n   = tail.esc ? CNT_W'(tail.iter - 1'b1) : tail.iter;
  assign fin_ext = {{COUNT_W{1'b0}}, fin_n};

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      count_r  <= fin_ext[COUNT_W-1:0];
      in_set_r <= !tail.esc;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = count_r;
  assign out_in_set          = in_set_r;

endmodule

FILE: rtl/core/mbe_cell.sv
// ----------------------------------------------------------------------------
// mbe_cell
// one ring cell: squares z in its first stage, then checks for escape and
// forms the next z in its second stage
// ----------------------------------------------------------------------------
module mbe_cell
  import mbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mbe_tok_t tok_i,
  output mbe_tok_t tok_o
);

  // products of the current z
  typedef struct packed {
    logic                     valid;
    logic                     done;
    logic                     esc;
    logic [CNT_W-1:0]         iter;
    logic signed [Q_W-1:0]    cr;
    logic signed [Q_W-1:0]    ci;
    logic [SQ_W-1:0]          rr;
    logic [SQ_W-1:0]          ii;
    logic signed [PROD_W-1:0] ri;
  } mbe_prod_t;

  mbe_prod_t prod_r, prod_nxt;
  mbe_tok_t  tok_r, tok_nxt;

  logic signed [Q_W-1:0]    re_s, im_s;
  logic signed [PROD_W-1:0] sq_re, sq_im, re_im;

  logic [PROD_W-1:0]        mag;
  logic                     esc_now;
  logic signed [SUM_W-1:0]  rr_w, ii_w, ri_w, cr_w, ci_w;
  logic signed [SUM_W-1:0]  sum_re, sum_im;

  // floor to q3.28 then clamp to the component range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-FRAC_W-1:0] q;
    logic                    fits;
    q    = v[SUM_W-1:FRAC_W];
    fits = (&q[SUM_W-FRAC_W-1:Q_W-1]) | ~(|q[SUM_W-FRAC_W-1:Q_W-1]);
    if (fits) begin
      return q[Q_W-1:0];
    end else if (q[SUM_W-FRAC_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  // stage one: two squares and cross product
  assign re_s  = tok_i.re;
  assign im_s  = tok_i.im;
  assign sq_re = re_s * re_s;
  assign sq_im = im_s * im_s;
  assign re_im = re_s * im_s;

  always_comb begin
    prod_nxt.valid = tok_i.valid;
    prod_nxt.done  = tok_i.done;
    prod_nxt.esc   = tok_i.esc;
    prod_nxt.iter  = tok_i.iter;
    prod_nxt.cr    = tok_i.cr;
    prod_nxt.ci    = tok_i.ci;
    prod_nxt.rr    = sq_re[SQ_W-1:0];
    prod_nxt.ii    = sq_im[SQ_W-1:0];
    prod_nxt.ri    = re_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  // stage two: escape test on the current z
  assign mag     = {1'b0, prod_r.rr} + {1'b0, prod_r.ii};
  assign esc_now = mag > ESC_LIMIT;

  // next z, exact before the floor
  assign rr_w   = {{(SUM_W-SQ_W){1'b0}}, prod_r.rr};
  assign ii_w   = {{(SUM_W-SQ_W){1'b0}}, prod_r.ii};
  assign ri_w   = {{(SUM_W-PROD_W-1){prod_r.ri[PROD_W-1]}}, prod_r.ri, 1'b0};
  assign cr_w   = {{(SUM_W-Q_W-FRAC_W){prod_r.cr[Q_W-1]}}, prod_r.cr, {FRAC_W{1'b0}}};
  assign ci_w   = {{(SUM_W-Q_W-FRAC_W){prod_r.ci[Q_W-1]}}, prod_r.ci, {FRAC_W{1'b0}}};
  assign sum_re = rr_w - ii_w + cr_w;
  assign sum_im = ri_w + ci_w;

  // finished points keep their flags and count, only z is still updated
  always_comb begin
    tok_nxt.valid = prod_r.valid;
    tok_nxt.done  = prod_r.done;
    tok_nxt.esc   = prod_r.esc;
    tok_nxt.iter  = prod_r.iter;
    tok_nxt.cr    = prod_r.cr;
    tok_nxt.ci    = prod_r.ci;
    tok_nxt.re    = sat_q(sum_re);
    tok_nxt.im    = sat_q(sum_im);
    if (!prod_r.done) begin
      if (esc_now) begin
        tok_nxt.done = 1'b1;
        tok_nxt.esc  = 1'b1;
      end else if (prod_r.iter == MAX_N) begin
        tok_nxt.done = 1'b1;
      end else begin
        tok_nxt.iter = CNT_W'(prod_r.iter + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/core/mbe_checker.sv
// ----------------------------------------------------------------------------
// mbe_checker
// port level checks of the escape time block, bound to its top level
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_defines.svh"

module mbe_checker
  import mbe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic signed [Q_W-1:0] in_c_real,
  input logic signed [Q_W-1:0] in_c_imag,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COUNT_W-1:0]    out_iteration_count,
  input logic                  out_in_set
);

  logic in_xfer;

  // input transfer seen at the ports
  assign in_xfer = in_valid && !in_stall && (in_c_real == in_c_real) &&
                   (in_c_imag == in_c_imag);

  // reset leaves the block empty and ready
  `MBE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && !in_stall, "not empty after reset")

  // only one point in work at a time
  `MBE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_xfer, in_stall, "ready again straight after a transfer")

  // a point in the set shows the full iteration limit
  `MBE_ASSERT_NOW(a_in_set_count, clk, rst_n, out_valid && out_in_set, out_iteration_count == MAX_COUNT_FIELD, "in set without full count")

  // a stalled result holds
  `MBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_iteration_count) && $stable(out_in_set), "stalled result changed")

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);
